/* rtl/bha_pkg.sv */
`default_nettype none

package bha_pkg;

  // symbol alphabet and counter sizes
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned CNT_W     = 40;
  localparam int unsigned ALPHA_N   = 1 << SYM_W;
  localparam int unsigned CHUNK_LW  = 4;
  localparam int unsigned CHUNK_W   = 1 << CHUNK_LW;
  localparam int unsigned CHUNK_N   = ALPHA_N / CHUNK_W;
  localparam int unsigned CUR_W     = SYM_W + 1;

  // request codes
  localparam logic [1:0] REQ_COUNT = 2'd0;
  localparam logic [1:0] REQ_MERGE = 2'd1;
  localparam logic [1:0] REQ_FETCH = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SYM_W-1:0] symbol;
    logic [CNT_W-1:0] amount;
  } bha_req_t;

  typedef struct packed {
    logic             found;
    logic [SYM_W-1:0] entry_symbol;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } bha_rsp_t;

  // counter memory port controls
  typedef struct packed {
    logic             we;
    logic [SYM_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic             re;
    logic [SYM_W-1:0] raddr;
  } bha_ram_req_t;

  typedef enum logic [1:0] {
    StIdle,
    StScanHit,
    StScanLast,
    StDone
  } bha_state_e;

endpackage

`default_nettype wire

/* rtl/bha_ram.sv */
`default_nettype none

module bha_ram
  import bha_pkg::*;
(
  input  wire logic         clk_i,
  input  wire bha_ram_req_t req_i,
  output logic [CNT_W-1:0]  rdata_o
);

  logic [CNT_W-1:0] mem_q [ALPHA_N];
  logic [CNT_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port, holds its value when idle
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/byte_histogram_accumulator.sv */
`default_nettype none

// channel | direction | handshake              | payload
// --------+-----------+------------------------+--------------------------
// in      | input     | in_valid_i / in_ready_o | in_i  (bha_req_t)
// out     | output    | out_valid_o/ out_ready_i| out_o (bha_rsp_t)
//
// count and merge transactions stream back to back outside a fetch:
// one counter memory read at accept, the saturating add and write in the next
// cycle, with a bypass register for the same symbol in consecutive items.
// a fetch walks a nonzero bitmap 16 symbols a cycle, first to the hit and
// then to the next nonzero symbol; input is held off meanwhile and while the
// output register stays full.
// reset and clear zero the bitmap and cursor at once; no memory sweep.
// a fetch result waits in the output register while later counts go on.

module byte_histogram_accumulator
  import bha_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bha_req_t in_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output bha_rsp_t      out_o
);

  // lowest set bit of a bitmap chunk
  function automatic logic [CHUNK_LW-1:0] lowest_set(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_LW-1:0] idx;
    idx = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (v[i]) idx = CHUNK_LW'(i);
    end
    return idx;
  endfunction

  bha_state_e state_q, state_d;

  logic                              s1_valid_q;
  logic [SYM_W-1:0]                  s1_sym_q;
  logic [CNT_W-1:0]                  s1_amt_q;
  logic                              byp_valid_q;
  logic [SYM_W-1:0]                  byp_sym_q;
  logic [CNT_W-1:0]                  byp_val_q;
  logic [CHUNK_N-1:0][CHUNK_W-1:0]   nz_q;
  logic [CUR_W-1:0]                  cursor_q, cursor_d;
  logic [CUR_W-1:0]                  pos_q, pos_d;
  logic [SYM_W-1:0]                  hit_sym_q, hit_sym_d;
  logic                              found_q, found_d;
  logic                              last_q, last_d;
  logic                              out_valid_q;
  bha_rsp_t                          out_q;

  logic             accept;
  logic             is_upd;
  logic             is_clear;
  logic             is_fetch;
  logic [CNT_W-1:0] rdata;
  logic [CNT_W-1:0] old_val;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] new_val;
  logic [CHUNK_W-1:0] scan_chunk;
  logic             scan_any;
  logic [SYM_W-1:0] scan_idx;
  logic [CUR_W-1:0] scan_next;
  logic [CUR_W-1:0] chunk_next;
  logic             out_load;
  bha_ram_req_t     ram_req;

  // input decode
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign is_upd     = accept && ((in_i.req_type == REQ_COUNT) || (in_i.req_type == REQ_MERGE));
  assign is_clear   = accept && (in_i.req_type == REQ_CLEAR);
  assign is_fetch   = accept && (in_i.req_type == REQ_FETCH);

  // read-modify-write: bypass covers the write landing with this read
  always_comb begin
    if (byp_valid_q && (byp_sym_q == s1_sym_q)) begin
      old_val = byp_val_q;
    end else if (nz_q[s1_sym_q[SYM_W-1:CHUNK_LW]][s1_sym_q[CHUNK_LW-1:0]]) begin
      old_val = rdata;
    end else begin
      old_val = '0;
    end
  end

  assign sum     = {1'b0, old_val} + {1'b0, s1_amt_q};
  assign new_val = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

  // bitmap scan over one chunk from the current position
  assign scan_chunk = nz_q[pos_q[SYM_W-1:CHUNK_LW]] & ({CHUNK_W{1'b1}} << pos_q[CHUNK_LW-1:0]);
  assign scan_any   = !pos_q[SYM_W] && (|scan_chunk);
  assign scan_idx   = {pos_q[SYM_W-1:CHUNK_LW], lowest_set(scan_chunk)};
  assign scan_next  = {1'b0, scan_idx} + CUR_W'(1);
  assign chunk_next = {pos_q[CUR_W-1:CHUNK_LW] + (CUR_W - CHUNK_LW)'(1), {CHUNK_LW{1'b0}}};

  // counter memory port
  always_comb begin
    ram_req.we    = s1_valid_q;
    ram_req.waddr = s1_sym_q;
    ram_req.wdata = new_val;
    ram_req.re    = is_upd || ((state_q == StScanHit) && scan_any);
    ram_req.raddr = (state_q == StIdle) ? in_i.symbol : scan_idx;
  end

  bha_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  // fetch sequencer: next state and outputs
  always_comb begin
    state_d   = state_q;
    cursor_d  = cursor_q;
    pos_d     = pos_q;
    hit_sym_d = hit_sym_q;
    found_d   = found_q;
    last_d    = last_q;
    out_load  = 1'b0;
    case (state_q)
      StIdle: begin
        if (is_fetch) begin
          pos_d   = cursor_q;
          state_d = StScanHit;
        end
        if (is_clear) begin
          cursor_d = '0;
        end
      end
      StScanHit: begin
        if (pos_q[SYM_W]) begin
          cursor_d = CUR_W'(ALPHA_N);
          found_d  = 1'b0;
          last_d   = 1'b1;
          state_d  = StDone;
        end else if (scan_any) begin
          cursor_d  = scan_next;
          pos_d     = scan_next;
          hit_sym_d = scan_idx;
          found_d   = 1'b1;
          state_d   = StScanLast;
        end else begin
          pos_d = chunk_next;
        end
      end
      StScanLast: begin
        if (pos_q[SYM_W]) begin
          last_d  = 1'b1;
          state_d = StDone;
        end else if (scan_any) begin
          last_d  = 1'b0;
          state_d = StDone;
        end else begin
          pos_d = chunk_next;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cursor_q    <= '0;
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      nz_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      s1_valid_q  <= is_upd;
      byp_valid_q <= s1_valid_q && !is_clear;
      // clear wins over the write that lands with it
      if (is_clear) begin
        nz_q <= '0;
      end else if (s1_valid_q && (|new_val)) begin
        nz_q[s1_sym_q[SYM_W-1:CHUNK_LW]][s1_sym_q[CHUNK_LW-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    hit_sym_q <= hit_sym_d;
    found_q   <= found_d;
    last_q    <= last_d;
    if (is_upd) begin
      s1_sym_q <= in_i.symbol;
      s1_amt_q <= (in_i.req_type == REQ_MERGE) ? in_i.amount : CNT_W'(1);
    end
    if (s1_valid_q) begin
      byp_sym_q <= s1_sym_q;
      byp_val_q <= new_val;
    end
    if (out_load) begin
      out_q.found        <= found_q;
      out_q.entry_symbol <= found_q ? hit_sym_q : '0;
      out_q.entry_count  <= found_q ? rdata : '0;
      out_q.last         <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

/* bench/histogram_checker.sv */
// watches both channels of the histogram block, keeps its own copy of the
// counters and the fetch cursor, and compares every fetch response in order
module histogram_checker
  import bha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  bha_req_t    in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  bha_rsp_t    out_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // predicted histogram and scan position
  logic [CNT_W-1:0] bin_count [ALPHA_N];
  logic [CUR_W-1:0] scan_pos;

  // fetch responses still owed by the block, oldest first
  bha_rsp_t expected_entries_q [$];

  function automatic void clear_histogram();
    foreach (bin_count[i]) bin_count[i] = '0;
    scan_pos = '0;
  endfunction

  // saturating add into one bin
  function automatic void add_to_bin(logic [SYM_W-1:0] sym, logic [CNT_W-1:0] amt);
    logic [CNT_W:0] sum;
    sum = {1'b0, bin_count[sym]} + {1'b0, amt};
    bin_count[sym] = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

  // next nonzero bin at or after the cursor, and whether another one follows
  function automatic bha_rsp_t next_nonzero_entry();
    bha_rsp_t    ent;
    int unsigned hit;
    int unsigned nxt;
    ent = '0;
    hit = scan_pos;
    while (hit < ALPHA_N && bin_count[hit] == '0) hit++;
    if (hit >= ALPHA_N) begin
      // nothing left: cursor parks at the end of the alphabet
      scan_pos = CUR_W'(ALPHA_N);
      ent.last = 1'b1;
    end else begin
      nxt = hit + 1;
      while (nxt < ALPHA_N && bin_count[nxt] == '0) nxt++;
      scan_pos = CUR_W'(hit + 1);
      ent.found        = 1'b1;
      ent.entry_symbol = SYM_W'(hit);
      ent.entry_count  = bin_count[hit];
      ent.last         = (nxt >= ALPHA_N);
    end
    return ent;
  endfunction

  task automatic check_field(string fld, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      mismatches_o++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fld, want, got);
    end
  endtask

  // responses are compared before the same edge's request is applied
  always @(posedge clk_i or negedge rst_ni) begin
    bha_rsp_t want;
    if (!rst_ni) begin
      clear_histogram();
      expected_entries_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      results_o    = 0;
      hits_o       = 0;
    end else begin
      // response transaction
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (out_i.found === 1'b1) hits_o++;
        if (expected_entries_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: response expected none, got %p", $time, out_i);
        end else begin
          want = expected_entries_q.pop_front();
          check_field("found", CNT_W'(want.found), CNT_W'(out_i.found));
          check_field("entry_symbol", CNT_W'(want.entry_symbol), CNT_W'(out_i.entry_symbol));
          check_field("entry_count", want.entry_count, out_i.entry_count);
          check_field("last", CNT_W'(want.last), CNT_W'(out_i.last));
        end
      end
      // request transaction
      if (in_valid_i && in_ready_i) begin
        case (in_i.req_type)
          REQ_COUNT: add_to_bin(in_i.symbol, CNT_W'(1));
          REQ_MERGE: add_to_bin(in_i.symbol, in_i.amount);
          REQ_FETCH: expected_entries_q.push_back(next_nonzero_entry());
          REQ_CLEAR: clear_histogram();
          default: ;
        endcase
      end
      pending_o = expected_entries_q.size();
    end
  end

endmodule

/* bench/tb_byte_histogram_accumulator.sv */
module tb_byte_histogram_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import bha_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam int unsigned      ITEMS_TARGET = 1950;
  localparam int unsigned      CYCLE_LIMIT  = 1000000;
  localparam int unsigned      RX_HOLD_LEN  = 400;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  bha_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  bha_rsp_t rsp;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned hits;

  int unsigned items_sent   = 0;
  int unsigned fetches_sent = 0;
  int unsigned burst_left   = 8;
  bit          rx_hold      = 1'b0;

  byte_histogram_accumulator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_i        (req),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_o       (rsp)
  );

  histogram_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_i   (req_ready),
    .in_i         (req),
    .out_valid_i  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .out_i        (rsp),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .hits_o       (hits)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("byte_histogram_accumulator: mismatch");
    $finish;
  end

  // response side: random stretches of ready, stalls and one long hold-off
  initial begin : rx_side
    int unsigned mode;
    int unsigned len;
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        rsp_ready <= 1'b0;
        repeat (RX_HOLD_LEN) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        mode = $urandom_range(0, 4);
        len  = $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            0, 1:    rsp_ready <= 1'b1;
            2:       rsp_ready <= 1'($urandom_range(0, 1));
            3:       rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [CNT_W-1:0] pick_amount();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return CNT_W'($urandom_range(1, 16));
      2:       return CNT_MAX;
      3:       return CNT_MAX - CNT_W'($urandom_range(0, 1000));
      default: return raw[CNT_W-1:0];
    endcase
  endfunction

  // one request transaction, then the burst/gap pattern of the sender
  task automatic send_req(input logic [1:0] kind, input logic [SYM_W-1:0] sym,
                          input logic [CNT_W-1:0] amt);
    int unsigned gap;
    req_valid <= 1'b1;
    req       <= '{req_type: kind, symbol: sym, amount: amt};
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (kind == REQ_FETCH) fetches_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 16);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender idles until every fetch response is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // fill a few bins spread over the alphabet, then walk them with fetches,
  // sometimes updating bins in the middle of the walk
  task automatic fill_and_walk(input bit do_clear);
    int unsigned      n_sym;
    int unsigned      n_upd;
    int unsigned      stride;
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] sym;
    n_sym  = $urandom_range(1, 12);
    n_upd  = $urandom_range(1, 30);
    stride = $urandom_range(1, 23);
    base   = SYM_W'($urandom);
    if (do_clear) send_req(REQ_CLEAR, SYM_W'($urandom), pick_amount());
    repeat (n_upd) begin
      case ($urandom_range(0, 9))
        0:       sym = '0;
        1:       sym = '1;
        default: sym = base + SYM_W'(stride * $urandom_range(0, n_sym - 1));
      endcase
      if ($urandom_range(0, 9) < 7) send_req(REQ_COUNT, sym, pick_amount());
      else send_req(REQ_MERGE, sym, pick_amount());
    end
    repeat (n_sym + $urandom_range(1, 4)) begin
      if ($urandom_range(0, 6) == 0)
        send_req($urandom_range(0, 1) ? REQ_COUNT : REQ_MERGE, SYM_W'($urandom),
                 pick_amount());
      send_req(REQ_FETCH, SYM_W'($urandom), pick_amount());
    end
  endtask

  // fully random requests
  task automatic send_noise(input int unsigned n);
    repeat (n) send_req(2'($urandom_range(REQ_COUNT, REQ_CLEAR)), SYM_W'($urandom),
                        pick_amount());
  endtask

  // stimulus and verdict
  initial begin : stim
    int unsigned episode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, cursor parked at the end
    send_req(REQ_CLEAR, '0, '0);
    send_req(REQ_FETCH, '0, '0);
    send_req(REQ_FETCH, '1, CNT_MAX);
    send_req(REQ_COUNT, 8'd5, '0);
    send_req(REQ_FETCH, '0, '0);
    // alphabet ends, saturation, zero merge, alternating bit patterns
    send_req(REQ_CLEAR, '1, CNT_MAX);
    send_req(REQ_COUNT, '0, CNT_MAX);
    send_req(REQ_COUNT, '1, '0);
    send_req(REQ_MERGE, '1, CNT_MAX);
    send_req(REQ_COUNT, '1, '0);
    send_req(REQ_MERGE, '0, '0);
    send_req(REQ_MERGE, 8'd128, 40'h55_5555_5555);
    send_req(REQ_MERGE, 8'd127, 40'hAA_AAAA_AAAA);
    send_req(REQ_MERGE, 8'd127, 40'hAA_AAAA_AAAA);
    // walk with updates behind and ahead of the cursor
    send_req(REQ_FETCH, '0, '0);
    send_req(REQ_FETCH, '0, '0);
    send_req(REQ_COUNT, 8'd1, '0);
    send_req(REQ_COUNT, 8'd200, '0);
    send_req(REQ_FETCH, '0, '0);
    send_req(REQ_FETCH, '0, '0);
    send_req(REQ_FETCH, '0, '0);
    send_req(REQ_FETCH, '0, '0);
    send_req(REQ_CLEAR, '0, '0);
    send_req(REQ_COUNT, 8'd7, '0);
    send_req(REQ_FETCH, '0, '0);
    wait_drained();

    // random episodes
    episode = 0;
    while (items_sent < ITEMS_TARGET) begin
      episode++;
      if (episode == 12) begin
        // long response hold-off while fetches pile up
        rx_hold = 1'b1;
        repeat (20) send_req(REQ_FETCH, SYM_W'($urandom), pick_amount());
        fill_and_walk(1'b1);
      end else if (episode % 25 == 0) begin
        wait_drained();
        fill_and_walk(1'b1);
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    send_noise($urandom_range(4, 30));
          2:       fill_and_walk(1'b0);
          default: fill_and_walk(1'b1);
        endcase
      end
    end

    // drain and let any stray response show up
    wait_drained();
    repeat (60) @(posedge clk);

    $display("sent %0d requests (%0d fetches) in %0d random episodes", items_sent,
             fetches_sent, episode);
    $display("checked %0d fetch responses, %0d of them returned an entry", results, hits);
    if (mismatches == 0 && pending == 0) begin
      $display("byte_histogram_accumulator: match");
    end else begin
      $display("byte_histogram_accumulator: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bha_pkg.sv
rtl/bha_ram.sv
rtl/byte_histogram_accumulator.sv
bench/histogram_checker.sv
bench/tb_byte_histogram_accumulator.sv
